[sv/keystream_byte_decrypt_checksum_core_defines.svh]
// Assertion macros shared by the keystream decrypt checksum core.
`ifndef KEYSTREAM_BYTE_DECRYPT_CHECKSUM_CORE_DEFINES_SVH
`define KEYSTREAM_BYTE_DECRYPT_CHECKSUM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KBDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/kbdc_pkg.sv]
// Types, codes and method tables for the keystream decrypt checksum core.
`timescale 1ns / 1ps

package kbdc_pkg;

    // Number of built-in keystream methods.
    localparam logic [2:0] NUM_METHODS = 3'd5;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_CHECK = 2'd2;

    // Kind codes of a result item.
    localparam logic KIND_PLAIN   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Method codes.
    localparam logic [2:0] METHOD_0 = 3'd0;
    localparam logic [2:0] METHOD_1 = 3'd1;
    localparam logic [2:0] METHOD_2 = 3'd2;
    localparam logic [2:0] METHOD_3 = 3'd3;
    localparam logic [2:0] METHOD_4 = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key_word;
        logic [31:0] check_word;
        logic [7:0]  cipher_byte;
    } req_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] plain_byte;
        logic       check_ok;
    } rsp_item_t;

    // Key mask of each method.
    function automatic logic [31:0] method_mask(input logic [2:0] m);
        logic [31:0] r;
        case (m)
            METHOD_1: r = 32'h91B2A2D1;
            METHOD_2: r = 32'h4A7C1B87;
            METHOD_3: r = 32'hF93941E6;
            METHOD_4: r = 32'hFD095E94;
            default:  r = 32'h4C358938;
        endcase
        return r;
    endfunction

    // Low-half adder constant of each method.
    function automatic logic [15:0] method_low_add(input logic [2:0] m);
        logic [15:0] r;
        case (m)
            METHOD_1: r = 16'h7D14;
            METHOD_2: r = 16'h1A82;
            METHOD_3: r = 16'h02BB;
            METHOD_4: r = 16'hE09C;
            default:  r = 16'h62E9;
        endcase
        return r;
    endfunction

    // High-half adder constant of each method.
    function automatic logic [15:0] method_high_add(input logic [2:0] m);
        logic [15:0] r;
        case (m)
            METHOD_1: r = 16'hA26B;
            METHOD_2: r = 16'hF03C;
            METHOD_3: r = 16'h7B12;
            METHOD_4: r = 16'h4E8F;
            default:  r = 16'h3619;
        endcase
        return r;
    endfunction

endpackage

[sv/keystream_byte_decrypt_checksum_core.sv]
// Top level of the keystream byte decryptor with running checksum check.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   req     | in        | req_valid / req_ready   | kbdc_pkg::req_item_t
//   rsp     | out       | rsp_valid / rsp_ready   | kbdc_pkg::rsp_item_t
//   cfg     | in        | cfg_valid / cfg_ready   | cfg_data, method select
//
// An item is taken into the input register, and once the result register is free the
// keystream generator, byte decrypt and checksum update run in one pass into the result
// register; byte and checksum items each give a result, and one item is taken every
// cycle while the result side is not stalled.
// The single generator step is the longest path: a five-term 16-bit add.
// Reset clears the generator, toggle, sums, method and both valid flags.
// A result that waits on rsp_ready holds the input register, which stalls req.
`timescale 1ns / 1ps
`include "keystream_byte_decrypt_checksum_core_defines.svh"

module keystream_byte_decrypt_checksum_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  kbdc_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kbdc_pkg::rsp_item_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_data
);

    // Input register and control state.
    logic                s1_valid_reg;
    kbdc_pkg::req_item_t s1_reg;
    logic [2:0]          method_reg;
    logic [31:0]         seed_reg;
    logic [31:0]         seed_next;
    logic                toggle_reg;
    logic                toggle_next;
    logic [7:0]          last_key_reg;
    logic [7:0]          last_key_next;
    logic [15:0]         sum_plain_reg;
    logic [15:0]         sum_plain_next;
    logic [15:0]         sum_rot_reg;
    logic [15:0]         sum_rot_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    kbdc_pkg::rsp_item_t rsp_reg;
    kbdc_pkg::rsp_item_t rsp_next;

    logic                out_free;
    logic                s1_fire;

    // Generator signals.
    logic                cm;
    logic                dm;
    logic [15:0]         hi_sh;
    logic [15:0]         lo_sh;
    logic [15:0]         key_hi;
    logic [15:0]         key_lo;
    logic [31:0]         seed_step;

    // Byte and checksum signals.
    logic [7:0]          plain;
    logic [15:0]         rot_top;
    logic [15:0]         c1;
    logic [15:0]         c2;

    // Terms used by the checks.
    logic                byte_fire;
    logic                start_fire;
    logic                plain_out;
    logic                state_clear;

    // Handshake control.
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // One generator step; carry terms are sign masks of seed bits.
    always_comb
    begin
        cm     = seed_reg[31];
        dm     = seed_reg[23];
        hi_sh  = cm ? 16'hFFFF : {seed_reg[22:8], 1'b0};
        lo_sh  = dm ? 16'hFFFF : {seed_reg[6:0], 9'b0};
        key_lo = lo_sh + seed_reg[15:0] + kbdc_pkg::method_low_add(method_reg);
        key_hi = hi_sh + seed_reg[31:16] + {16{cm}}
                 + kbdc_pkg::method_high_add(method_reg) + {16{dm}};
        seed_step = {key_hi + {16{key_lo[15]}}, key_lo};
    end

    // Start, decrypt, checksum update and verdict for the item in the input register.
    always_comb
    begin
        seed_next      = seed_reg;
        toggle_next    = toggle_reg;
        last_key_next  = last_key_reg;
        sum_plain_next = sum_plain_reg;
        sum_rot_next   = sum_rot_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        plain          = 8'd0;
        rot_top        = {{12{sum_rot_reg[15]}}, sum_rot_reg[15:12]};
        c1             = s1_reg.check_word[31:16] ^ key_hi;
        c2             = s1_reg.check_word[15:0] - key_hi;
        if (s1_fire)
        begin
            rsp_valid_next = 1'b0;
            case (s1_reg.func)
                kbdc_pkg::FUNC_START:
                begin
                    seed_next      = s1_reg.key_word ^ kbdc_pkg::method_mask(method_reg);
                    toggle_next    = 1'b0;
                    last_key_next  = 8'd0;
                    sum_plain_next = 16'd0;
                    sum_rot_next   = 16'd0;
                end
                kbdc_pkg::FUNC_BYTE:
                begin
                    if (toggle_reg)
                    begin
                        plain = s1_reg.cipher_byte - last_key_reg;
                    end
                    else
                    begin
                        seed_next     = seed_step;
                        last_key_next = key_hi[7:0];
                        plain         = s1_reg.cipher_byte ^ key_hi[7:0];
                    end
                    toggle_next         = !toggle_reg;
                    sum_plain_next      = sum_plain_reg + {8'd0, plain};
                    sum_rot_next        = {sum_rot_reg[11:0], 4'd0} + rot_top + {8'd0, plain};
                    rsp_valid_next      = 1'b1;
                    rsp_next.kind       = kbdc_pkg::KIND_PLAIN;
                    rsp_next.plain_byte = plain;
                    rsp_next.check_ok   = 1'b0;
                end
                kbdc_pkg::FUNC_CHECK:
                begin
                    seed_next           = seed_step;
                    rsp_valid_next      = 1'b1;
                    rsp_next.kind       = kbdc_pkg::KIND_VERDICT;
                    rsp_next.plain_byte = 8'd0;
                    rsp_next.check_ok   = (c1 == sum_plain_reg) && (c2 == sum_rot_reg);
                end
                default:
                begin
                    rsp_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Control state and valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            method_reg    <= kbdc_pkg::METHOD_0;
            seed_reg      <= 32'd0;
            toggle_reg    <= 1'b0;
            last_key_reg  <= 8'd0;
            sum_plain_reg <= 16'd0;
            sum_rot_reg   <= 16'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (cfg_valid && (cfg_data < kbdc_pkg::NUM_METHODS))
            begin
                method_reg <= cfg_data;
            end
            seed_reg      <= seed_next;
            toggle_reg    <= toggle_next;
            last_key_reg  <= last_key_next;
            sum_plain_reg <= sum_plain_next;
            sum_rot_reg   <= sum_rot_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    // Conditions watched by the checks below.
    assign byte_fire   = s1_fire && (s1_reg.func == kbdc_pkg::FUNC_BYTE);
    assign start_fire  = s1_fire && (s1_reg.func == kbdc_pkg::FUNC_START);
    assign plain_out   = rsp_valid_reg && (rsp_reg.kind == kbdc_pkg::KIND_PLAIN);
    assign state_clear = !toggle_reg && (sum_plain_reg == 16'd0)
                         && (sum_rot_reg == 16'd0) && !rsp_valid_reg;

    // Checks on the block's own logic.
    `KBDC_ASSERT_NOW(a_method_range, 1'b1, method_reg < kbdc_pkg::NUM_METHODS, "bad method")
    `KBDC_ASSERT_NEXT(a_byte_gives_plain, byte_fire, plain_out, "byte item gave no plain result")
    `KBDC_ASSERT_NEXT(a_start_clears, start_fire, state_clear, "start item did not clear state")

endmodule

[bench/kbdc_stream_checker.sv]
// Checker for the keystream decrypt core: predicts each result and compares it.
`timescale 1ns / 1ps

module kbdc_stream_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  kbdc_pkg::req_item_t req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  kbdc_pkg::rsp_item_t rsp,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_data,
    output int                  fail_count,
    output int                  outstanding,
    output logic [31:0]         match_check
);

    // Per-method constants, method 0 in the lowest slice.
    localparam logic [159:0] KEY_MASKS = {32'hFD095E94, 32'hF93941E6, 32'h4A7C1B87,
                                          32'h91B2A2D1, 32'h4C358938};
    localparam logic [79:0]  LOW_ADDS  = {16'hE09C, 16'h02BB, 16'h1A82, 16'h7D14, 16'h62E9};
    localparam logic [79:0]  HIGH_ADDS = {16'h4E8F, 16'h7B12, 16'hF03C, 16'hA26B, 16'h3619};

    // Predicted state of the core.
    logic [2:0]          method_sel;
    logic [31:0]         seed;
    logic                odd_pos;
    logic [7:0]          key_byte;
    logic [15:0]         sum_plain;
    logic [15:0]         sum_rot;
    int                  errors;
    kbdc_pkg::rsp_item_t awaited_rsp_q[$];

    // Scratch values of the prediction.
    kbdc_pkg::rsp_item_t predicted;
    kbdc_pkg::rsp_item_t oldest;
    logic [47:0]         step;
    logic [15:0]         c1;
    logic [15:0]         c2;
    logic [7:0]          p;

    // One generator step: returns the next seed over the 16-bit key word.
    function automatic logic [47:0] keystream_step(input logic [31:0] s, input logic [2:0] m);
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] cm;
        logic [15:0] dm;
        logic [31:0] lo_ext;
        hi = s[23:8];
        lo = {s[7:0], 8'h00};
        cm = {16{s[31]}};
        dm = {16{hi[15]}};
        hi = (hi << 1) | cm;
        lo = (lo << 1) | dm;
        lo = lo + s[15:0];
        hi = hi + s[31:16] + cm;
        lo = lo + LOW_ADDS[m * 16 +: 16];
        hi = hi + HIGH_ADDS[m * 16 +: 16] + dm;
        lo_ext = {{16{lo[15]}}, lo};
        return {{hi, 16'h0000} + lo_ext, hi};
    endfunction

    // Rotating sum: shift left by four, add the sign-extended top nibble and the byte.
    function automatic logic [15:0] rotmix_add(input logic [15:0] r, input logic [7:0] b);
        return (r << 4) + {{12{r[15]}}, r[15:12]} + {8'h00, b};
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            method_sel = kbdc_pkg::METHOD_0;
            seed       = '0;
            odd_pos    = 1'b0;
            key_byte   = '0;
            sum_plain  = '0;
            sum_rot    = '0;
            errors     = 0;
            awaited_rsp_q.delete();
        end else begin
            // Compare an accepted result with the oldest prediction.
            if (rsp_valid && rsp_ready) begin
                if (awaited_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, rsp);
                    errors++;
                end else begin
                    oldest = awaited_rsp_q.pop_front();
                    if (rsp.kind !== oldest.kind) begin
                        $display("%0t: kind mismatch, expected %h, actual %h",
                                 $time, oldest.kind, rsp.kind);
                        errors++;
                    end
                    if (rsp.plain_byte !== oldest.plain_byte) begin
                        $display("%0t: plain_byte mismatch, expected %h, actual %h",
                                 $time, oldest.plain_byte, rsp.plain_byte);
                        errors++;
                    end
                    if (rsp.check_ok !== oldest.check_ok) begin
                        $display("%0t: check_ok mismatch, expected %h, actual %h",
                                 $time, oldest.check_ok, rsp.check_ok);
                        errors++;
                    end
                end
            end

            // Method writes outside the table are dropped.
            if (cfg_valid && cfg_ready && cfg_data < kbdc_pkg::NUM_METHODS) begin
                method_sel = cfg_data;
            end

            // Advance the predicted state for an accepted input item.
            if (req_valid && req_ready) begin
                case (req.func)
                    kbdc_pkg::FUNC_START: begin
                        seed      = req.key_word ^ KEY_MASKS[method_sel * 32 +: 32];
                        odd_pos   = 1'b0;
                        key_byte  = '0;
                        sum_plain = '0;
                        sum_rot   = '0;
                    end
                    kbdc_pkg::FUNC_BYTE: begin
                        if (odd_pos) begin
                            p = req.cipher_byte - key_byte;
                        end else begin
                            step     = keystream_step(seed, method_sel);
                            seed     = step[47:16];
                            key_byte = step[7:0];
                            p        = req.cipher_byte ^ key_byte;
                        end
                        odd_pos   = ~odd_pos;
                        sum_plain = sum_plain + {8'h00, p};
                        sum_rot   = rotmix_add(sum_rot, p);
                        predicted.kind       = kbdc_pkg::KIND_PLAIN;
                        predicted.plain_byte = p;
                        predicted.check_ok   = 1'b0;
                        awaited_rsp_q.push_back(predicted);
                    end
                    kbdc_pkg::FUNC_CHECK: begin
                        step = keystream_step(seed, method_sel);
                        seed = step[47:16];
                        c1   = req.check_word[31:16] ^ step[15:0];
                        c2   = req.check_word[15:0] - step[15:0];
                        predicted.kind       = kbdc_pkg::KIND_VERDICT;
                        predicted.plain_byte = '0;
                        predicted.check_ok   = (c1 == sum_plain) && (c2 == sum_rot);
                        awaited_rsp_q.push_back(predicted);
                    end
                    default: begin
                        // The unused code leaves everything as it was.
                    end
                endcase
            end
        end

        // Check words that would pass if a checksum item came next.
        step = keystream_step(seed, method_sel);
        match_check <= {sum_plain ^ step[15:0], sum_rot + step[15:0]};
        outstanding <= awaited_rsp_q.size();
        fail_count  <= errors;
    end

endmodule

[bench/tb.sv]
// Top of the keystream decrypt core testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         ITEM_TARGET    = 950;
    localparam int         QUIET_LIMIT    = 2000;
    localparam int         LONG_HOLD      = 200;
    localparam int         DRAIN_CYCLES   = 4;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_ALTERNATE} stall_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    kbdc_pkg::req_item_t req       = '0;
    logic                rsp_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [2:0]          cfg_data  = kbdc_pkg::METHOD_0;
    logic                req_ready;
    logic                rsp_valid;
    kbdc_pkg::rsp_item_t rsp;
    logic                cfg_ready;

    int          fail_count;
    int          outstanding;
    logic [31:0] match_check;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    int          burst_left   = 0;

    keystream_byte_decrypt_checksum_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    kbdc_stream_checker stream_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .match_check (match_check)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Offer one item and hold it until it is taken.
    task automatic send_item(input kbdc_pkg::req_item_t it);
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if (it.func != FUNC_UNUSED) items_sent++;
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sender bursts: random length, separated by random gaps that may be empty.
    task automatic next_slot();
        if (burst_left == 0)
        begin
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
    endtask

    function automatic kbdc_pkg::req_item_t random_item(input logic [1:0] func);
        kbdc_pkg::req_item_t it;
        it.func        = func;
        it.key_word    = $urandom;
        it.check_word  = $urandom;
        it.cipher_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic logic [31:0] random_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0:       k = '0;
            1:       k = '1;
            2:       k = 32'h8000_0000;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic send_start(input logic [31:0] key);
        kbdc_pkg::req_item_t it;
        it          = random_item(kbdc_pkg::FUNC_START);
        it.key_word = key;
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        kbdc_pkg::req_item_t it;
        it             = random_item(kbdc_pkg::FUNC_BYTE);
        it.cipher_byte = b;
        send_item(it);
    endtask

    task automatic send_noise();
        send_item(random_item(FUNC_UNUSED));
    endtask

    // A passing checksum needs the state after every earlier item, so idle the
    // request line and let the checker catch up before reading it.
    task automatic send_check(input logic good);
        kbdc_pkg::req_item_t it;
        req_valid <= 1'b0;
        @(posedge clk);
        it = random_item(kbdc_pkg::FUNC_CHECK);
        if (good)
            it.check_word = match_check;
        else if ($urandom_range(0, 1) == 0)
            it.check_word = match_check ^ (32'h1 << $urandom_range(0, 31));
        send_item(it);
    endtask

    // Wait until every predicted result is back and the pipeline is empty.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_method(input logic [2:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed stream with random content, with some noise mixed in.
    task automatic run_session();
        int n_bytes;
        int k;
        if ($urandom_range(0, 5) == 0) write_method(3'($urandom_range(0, 7)));
        if ($urandom_range(0, 9) != 0)
        begin
            next_slot();
            send_start(random_key());
        end
        n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
        for (k = 0; k < n_bytes; k++)
        begin
            next_slot();
            if ($urandom_range(0, 39) == 0) send_noise();
            send_byte(8'($urandom_range(0, 255)));
        end
        next_slot();
        send_check($urandom_range(0, 9) < 7);
        // Sometimes the stream goes on past the checksum item.
        if ($urandom_range(0, 4) == 0)
        begin
            n_bytes = $urandom_range(1, 8);
            for (k = 0; k < n_bytes; k++)
            begin
                next_slot();
                send_byte(8'($urandom_range(0, 255)));
            end
            next_slot();
            send_check(1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        kbdc_pkg::req_item_t it;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Out-of-range methods must be dropped, leaving method 0.
        write_method(3'd7);
        write_method(3'd5);

        // Bytes and a checksum straight from the reset state.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_check(1'b1);

        // The unused function code with every payload bit set.
        it = '1;
        send_item(it);

        // All-ones key, extreme bytes, bytes past the checksum and a bad checksum.
        send_start(32'hFFFF_FFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h01);
        send_check(1'b1);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_check(1'b0);

        // Highest method with a zero key and with only the sign bit set.
        write_method(kbdc_pkg::METHOD_4);
        send_start(32'h0000_0000);
        send_byte(8'h00);
        send_check(1'b0);
        send_start(32'h8000_0000);
        send_byte(8'hFF);
        send_check(1'b1);
        write_method(kbdc_pkg::METHOD_0);

        while (items_sent < ITEM_TARGET) run_session();

        settle();
        if (fail_count == 0)
            $display("keystream_byte_decrypt_checksum_core verification clean");
        else
            $display("keystream_byte_decrypt_checksum_core verification failed");
        $finish;
    end

    // Receiver: random stall patterns, with a long hold-off now and then so
    // that the core fills up and pushes back on its input.
    initial
    begin
        stall_mode_t mode;
        int          seg_len;
        int          next_hold;
        next_hold = 250;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (results_seen >= next_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                next_hold += 400;
            end
            mode    = stall_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(1, 48);
            repeat (seg_len)
            begin
                case (mode)
                    STALL_NONE:  rsp_ready <= 1'b1;
                    STALL_HALF:  rsp_ready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default:     rsp_ready <= ~rsp_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    // Count results and watch for a run in which nothing moves.
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready) results_seen <= results_seen + 1;
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("keystream_byte_decrypt_checksum_core verification failed");
                $finish;
            end
        end
    end

endmodule
